// ===== hw/rtl/wbps_pkg.sv =====
// wbps_pkg: shared types and constants for the wildcard byte pattern search
// used by wbps_cell, wbps_align, the top level and its checker
// no dependencies
package wbps_pkg;

  // fixed field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned LenW     = 7;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned PatchW   = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // number of pattern positions the entry index can reach
  localparam int unsigned EntryCnt = 1 << IdxW;

  // width for comparing lengths, counts and cell indexes (values up to 511)
  localparam int unsigned CmpW = 9;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_SCAN  = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_READY     = 3'd0,
    ST_SEARCHING = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_PATCH  = 2'd2
  } cfg_reg_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [IdxW-1:0]  entry_index;
    logic [ByteW-1:0] pattern_byte;
    logic             care;
    logic [LenW-1:0]  len;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/wbps_cell.sv =====
// wbps_cell: one pattern position of the search chain
// holds a pattern byte with its care bit and one history byte, compares its window byte
// depends on wbps_pkg
module wbps_cell
  import wbps_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] win_i,
  output logic [ByteW-1:0] byte_o,
  output logic             hit_o
);

  localparam bit               Reach   = Idx < EntryCnt;
  localparam logic [IdxW-1:0]  IdxCode = IdxW'(Idx % EntryCnt);
  localparam logic [CmpW-1:0]  IdxWide = CmpW'(Idx);

  logic [ByteW-1:0] pat_q;
  logic             care_q;
  logic [ByteW-1:0] hist_q;

  // pattern entry load and history shift toward the next cell
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && Reach && (ctl_i.entry_index == IdxCode)) begin
      pat_q  <= ctl_i.pattern_byte;
      care_q <= ctl_i.care;
    end
    if (ctl_i.shift) begin
      hist_q <= byte_i;
    end
  end

  assign byte_o = hist_q;

  // positions past the pattern length and wildcards always hit
  assign hit_o = (IdxWide >= CmpW'(ctl_i.len)) | ~care_q | (pat_q == win_i);

endmodule

// ===== hw/rtl/wbps_align.sv =====
// wbps_align: log-depth shifter that lines the byte history up with pattern positions
// input is in lag order (current byte first), output is indexed by pattern position
// depends on wbps_pkg
module wbps_align
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = 64,
  parameter int unsigned ShW        = 6
) (
  input  logic [MaxPattern-1:0][ByteW-1:0] lag_i,
  input  logic [ShW-1:0]                   sh_i,
  output logic [MaxPattern-1:0][ByteW-1:0] win_o
);

  logic [MaxPattern-1:0][ByteW-1:0] stg [ShW+1];

  // reverse to oldest-first order
  for (genvar t = 0; t < MaxPattern; t++) begin : g_rev
    assign stg[0][t] = lag_i[MaxPattern-1-t];
  end

  // one shift stage per bit of the shift amount
  for (genvar s = 0; s < ShW; s++) begin : g_stage
    for (genvar i = 0; i < MaxPattern; i++) begin : g_pos
      if (i + (1 << s) < MaxPattern) begin : g_move
        assign stg[s+1][i] = sh_i[s] ? stg[s][i+(1<<s)] : stg[s][i];
      end else begin : g_edge
        assign stg[s+1][i] = sh_i[s] ? '0 : stg[s][i];
      end
    end
  end

  assign win_o = stg[ShW];

endmodule

// ===== hw/rtl/wildcard_byte_pattern_search.sv =====
// wildcard_byte_pattern_search: top level of the masked byte pattern search
// instantiates wbps_cell (one per pattern position) and wbps_align
// depends on wbps_pkg
//
// Usage
//   Config port (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0 pattern
//   length, 1 region base, 2 patch offset. Always ready; write only while idle.
//   Input channel (in_valid_i/in_ready_o): each beat is a load of one pattern entry,
//   a start that clears the search, or one scanned data byte with its end mark.
//   Output channel (out_valid_o/out_ready_i): exactly one result beat per input beat,
//   carrying status, match offset and patch address.
// Timing
//   A result passes two registers on its way out: the first register takes
//   the match decision over all cells, the second adds base, offset and patch offset.
//   Throughput is one beat per cycle while the output is not stalled; the chain
//   compares every pattern position in parallel on each data byte.
// Stalls and reset
//   When the receiver holds out_ready_i low, the two result registers still absorb
//   input beats until both are full; then in_ready_o drops until a result is taken.
//   Reset clears the config registers (pattern invalid) and the search state. The
//   pattern store is not cleared; load every position in use before scanning.
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic [ByteW-1:0]    pattern_byte_i,
  input  logic                care_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                end_of_region_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [AddrW-1:0]    match_offset_o,
  output logic [AddrW-1:0]    patch_address_o
);

  localparam int unsigned ShW   = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned SeenW = $clog2(MaxPattern + 1);
  localparam logic [SeenW-1:0] SeenMax = SeenW'(MaxPattern);
  localparam logic [CmpW-1:0]  MaxWide = CmpW'(MaxPattern);

  // config registers
  logic [LenW-1:0]   len_q;
  logic [AddrW-1:0]  base_q;
  logic [PatchW-1:0] patch_q;

  // search state
  logic [SeenW-1:0] seen_q, seen_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             fin_q, fin_d;
  logic             found_q, found_d;
  logic [AddrW-1:0] foff_q, foff_d;

  // result pipeline
  logic             s1_valid_q;
  status_e          s1_st_q, st_d;
  logic [AddrW-1:0] s1_off_q, off_d;
  logic             out_valid_q;
  status_e          out_st_q;
  logic [AddrW-1:0] out_off_q;
  logic [AddrW-1:0] out_patch_q;

  logic in_fire, s1_adv, s2_adv;
  logic len_ok, win_ok, match, shift;

  logic [MaxPattern-1:0][ByteW-1:0] hist;
  logic [MaxPattern-1:0][ByteW-1:0] lag;
  logic [MaxPattern-1:0][ByteW-1:0] win;
  logic [MaxPattern-1:0]            hit;
  logic [CmpW-1:0]                  sh_full;
  cell_ctl_t                        ctl;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign s2_adv      = !out_valid_q || out_ready_i;
  assign s1_adv      = !s1_valid_q || s2_adv;
  assign in_ready_o  = s1_adv;
  assign in_fire     = in_valid_i && in_ready_o;

  // config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      base_q  <= '0;
      patch_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LENGTH: len_q   <= cfg_data_i[LenW-1:0];
        CFG_BASE:   base_q  <= cfg_data_i[AddrW-1:0];
        CFG_PATCH:  patch_q <= cfg_data_i[PatchW-1:0];
        default:    ;
      endcase
    end
  end

  // cell chain: each cell after the first takes its history byte from the previous one, the first from the data byte
  assign ctl.load         = in_fire && (opcode_i == OP_LOAD);
  assign ctl.shift        = shift;
  assign ctl.entry_index  = entry_index_i;
  assign ctl.pattern_byte = pattern_byte_i;
  assign ctl.care         = care_i;
  assign ctl.len          = len_q;

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    logic [ByteW-1:0] nbr;
    if (i == 0) begin : g_head
      assign nbr    = data_byte_i;
      assign lag[0] = data_byte_i;
    end else begin : g_body
      assign nbr    = hist[i-1];
      assign lag[i] = hist[i-1];
    end
    wbps_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .byte_i (nbr),
      .win_i  (win[i]),
      .byte_o (hist[i]),
      .hit_o  (hit[i])
    );
  end

  // line the window up so the current byte meets pattern position len-1
  assign sh_full = MaxWide - CmpW'(len_q);

  wbps_align #(
    .MaxPattern (MaxPattern),
    .ShW        (ShW)
  ) u_align (
    .lag_i (lag),
    .sh_i  (sh_full[ShW-1:0]),
    .win_o (win)
  );

  // match decision
  assign len_ok = (len_q != '0) && (CmpW'(len_q) <= MaxWide);
  assign win_ok = (CmpW'(seen_q) + CmpW'(1)) >= CmpW'(len_q);
  assign match  = win_ok && (&hit);

  // next search state and first-stage result for the current beat
  always_comb begin
    seen_d  = seen_q;
    pos_d   = pos_q;
    fin_d   = fin_q;
    found_d = found_q;
    foff_d  = foff_q;
    shift   = 1'b0;
    st_d    = ST_READY;
    off_d   = '0;
    unique case (opcode_i)
      OP_LOAD: begin
        st_d = ST_READY;
      end
      OP_START: begin
        seen_d  = '0;
        pos_d   = '0;
        fin_d   = 1'b0;
        found_d = 1'b0;
        foff_d  = '0;
        st_d    = len_ok ? ST_READY : ST_INVALID;
      end
      OP_SCAN: begin
        if (!len_ok) begin
          st_d = ST_INVALID;
        end else if (fin_q) begin
          st_d  = found_q ? ST_FOUND : ST_NOT_FOUND;
          off_d = found_q ? foff_q : '0;
        end else begin
          shift  = in_fire;
          seen_d = (seen_q == SeenMax) ? seen_q : seen_q + SeenW'(1);
          pos_d  = pos_q + AddrW'(1);
          if (match) begin
            foff_d  = pos_q - AddrW'(len_q - LenW'(1));
            fin_d   = 1'b1;
            found_d = 1'b1;
            st_d    = ST_FOUND;
            off_d   = foff_d;
          end else if (end_of_region_i) begin
            fin_d = 1'b1;
            st_d  = ST_NOT_FOUND;
          end else begin
            st_d = ST_SEARCHING;
          end
        end
      end
      default: begin
        st_d = ST_READY;
      end
    endcase
  end

  // search state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      pos_q   <= '0;
      fin_q   <= 1'b0;
      found_q <= 1'b0;
      foff_q  <= '0;
    end else if (in_fire) begin
      seen_q  <= seen_d;
      pos_q   <= pos_d;
      fin_q   <= fin_d;
      found_q <= found_d;
      foff_q  <= foff_d;
    end
  end

  // result stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // result stage payload, patch address formed in the second stage
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_st_q  <= st_d;
      s1_off_q <= off_d;
    end
    if (s2_adv && s1_valid_q) begin
      out_st_q    <= s1_st_q;
      out_off_q   <= s1_off_q;
      out_patch_q <= (s1_st_q == ST_FOUND) ? (base_q + s1_off_q + AddrW'(patch_q)) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign match_offset_o  = out_off_q;
  assign patch_address_o = out_patch_q;

endmodule

// ===== hw/rtl/wbps_chk.sv =====
// wbps_chk: port-level checker for wildcard_byte_pattern_search, with its bind
// watches the input and output channels over time
// depends on wbps_pkg
module wbps_chk
  import wbps_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_o,
  input logic [AddrW-1:0]   match_offset_o,
  input logic [AddrW-1:0]   patch_address_o
);

  // a stalled result beat holds its payload
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(match_offset_o) && $stable(patch_address_o))
    else $error("result beat changed while stalled");

  // input is only held off when both result registers are full and stalled
  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // offset and address are zero unless a match is reported
  a_zero_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FOUND) |-> (match_offset_o == '0) &&
      (patch_address_o == '0))
    else $error("nonzero offset or address without a match");

  // nothing is presented right after reset
  a_reset_empty : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat present at reset release");

endmodule

bind wildcard_byte_pattern_search wbps_chk u_wbps_chk (.*);
